// ----- rtl/core/cmrl_pkg.sv -----
// Shared types, sizes and helper functions for the count-min rate limiter.
// No dependencies; every other file but cmrl_ram refers to it by scoped names.
package cmrl_pkg;

    localparam int LINE_BITS   = 10;
    localparam int LINES       = 1 << LINE_BITS;
    localparam int FIELD_LINE_W = 10;
    localparam int HASH_W      = 30;
    localparam int PRICE_W     = 32;
    localparam int CNT_W       = 32;
    localparam int PER_LINE    = 15;
    localparam int TABLES      = 2;
    localparam int PICKS       = 4;
    localparam int STEPS       = TABLES * PICKS;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int POS_W       = 4;
    localparam int DIV_W       = 4;
    localparam int ROW_W       = PER_LINE * CNT_W;
    localparam int SLOTS       = TABLES * PER_LINE;
    localparam int SLOTS_PAD   = 32;
    localparam int MIN_GROUPS  = SLOTS_PAD / 4;
    localparam int MIN_PAIRS   = MIN_GROUPS / 4;

    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_W     = 31;
    localparam int PROD_W      = HASH_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_D15 = RECIP_W'((64'd1 << RECIP_SHIFT) / 15);
    localparam logic [RECIP_W-1:0] RECIP_D14 = RECIP_W'((64'd1 << RECIP_SHIFT) / 14);
    localparam logic [RECIP_W-1:0] RECIP_D13 = RECIP_W'((64'd1 << RECIP_SHIFT) / 13);
    localparam logic [RECIP_W-1:0] RECIP_D12 = RECIP_W'((64'd1 << RECIP_SHIFT) / 12);

    localparam logic [DIV_W-1:0] DIV_FIRST = DIV_W'(PER_LINE);

    typedef logic [LINE_BITS-1:0] line_t;
    typedef logic [HASH_W-1:0]    hash_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [PER_LINE-1:0]  mask_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [STEP_W-1:0]    step_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [DIV_W-1:0]     div_t;
    typedef logic [1:0]           pick_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic digit;
        logic scan;
        logic reduce1;
        logic reduce2;
        logic add;
        logic wr;
        logic clear;
        logic result;
    } cmd_t;

    typedef struct packed {
        logic digits_done;
        logic clear_done;
    } status_t;

    function automatic div_t divisor(input pick_t pick);
        return DIV_FIRST - div_t'(pick);
    endfunction

    function automatic logic [RECIP_W-1:0] recip(input pick_t pick);
        logic [RECIP_W-1:0] m;
        case (pick)
            2'd0:    m = RECIP_D15;
            2'd1:    m = RECIP_D14;
            2'd2:    m = RECIP_D13;
            2'd3:    m = RECIP_D12;
            default: m = RECIP_D15;
        endcase
        return m;
    endfunction

    // One-hot position of the rank-th free counter, counted upward.
    function automatic mask_t nth_zero(input mask_t used, input pos_t rank);
        mask_t hit;
        pos_t  cnt;
        hit = '0;
        for (int k = 0; k < PER_LINE; k++)
        begin
            cnt = '0;
            for (int j = 0; j < PER_LINE; j++)
            begin
                if (j < k)
                begin
                    cnt = cnt + pos_t'(!used[j]);
                end
            end
            if (!used[k] && (cnt == rank))
            begin
                hit[k] = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic cnt_t min_of(input cnt_t a, input cnt_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ----- rtl/core/cmrl_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cmrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/cmrl_datapath.sv -----
// Datapath: counter tables, pick-hash digit unit, limit check, minimum tree and update.
// Depends on cmrl_pkg and cmrl_ram; driven by commands from cmrl_ctrl.
module cmrl_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cmrl_pkg::cmd_t                        cmd,
    output cmrl_pkg::status_t                     status,
    input  logic [cmrl_pkg::FIELD_LINE_W-1:0]     line_first,
    input  logic [cmrl_pkg::FIELD_LINE_W-1:0]     line_second,
    input  logic [cmrl_pkg::HASH_W-1:0]           pick_hash,
    input  logic [cmrl_pkg::PRICE_W-1:0]          price,
    output logic                                  limited
);

    cmrl_pkg::line_t  line_reg [cmrl_pkg::TABLES];
    cmrl_pkg::hash_t  hash_reg;
    cmrl_pkg::hash_t  q_est_reg;
    cmrl_pkg::cnt_t   price_reg;
    cmrl_pkg::step_t  step_reg;
    cmrl_pkg::mask_t  mask_reg [cmrl_pkg::TABLES];
    cmrl_pkg::cnt_t   min8_reg [cmrl_pkg::MIN_GROUPS];
    cmrl_pkg::cnt_t   min2_reg [cmrl_pkg::MIN_PAIRS];
    cmrl_pkg::cnt_t   min_reg;
    cmrl_pkg::cnt_t   sum_reg;
    logic             under_reg;
    logic             limited_reg;
    cmrl_pkg::line_t  clear_idx_reg;

    cmrl_pkg::line_t  rd_addr [cmrl_pkg::TABLES];
    cmrl_pkg::line_t  wr_addr [cmrl_pkg::TABLES];
    cmrl_pkg::row_t   rd_row  [cmrl_pkg::TABLES];
    cmrl_pkg::row_t   wr_row  [cmrl_pkg::TABLES];
    logic             wr_en;

    cmrl_pkg::pick_t  pick;
    logic             tsel;
    cmrl_pkg::div_t   div;
    logic [cmrl_pkg::PROD_W-1:0] prod;
    cmrl_pkg::hash_t  q_est_next;
    cmrl_pkg::hash_t  qd;
    cmrl_pkg::hash_t  r_est;
    logic             fix;
    cmrl_pkg::hash_t  r_fix;
    cmrl_pkg::hash_t  q_next;
    cmrl_pkg::mask_t  pos_hit;

    cmrl_pkg::cnt_t   limit;
    cmrl_pkg::cnt_t   slot_val [cmrl_pkg::SLOTS_PAD];
    logic             under_next;
    cmrl_pkg::cnt_t   min8_next [cmrl_pkg::MIN_GROUPS];
    cmrl_pkg::cnt_t   min2_next [cmrl_pkg::MIN_PAIRS];
    logic [cmrl_pkg::CNT_W:0] add_full;
    cmrl_pkg::cnt_t   cnt_v;

    assign rd_addr[0] = cmrl_pkg::line_t'(line_first);
    assign rd_addr[1] = cmrl_pkg::line_t'(line_second);

    for (genvar t = 0; t < cmrl_pkg::TABLES; t++)
    begin : g_table
        assign wr_addr[t] = cmd.clear ? clear_idx_reg : line_reg[t];

        cmrl_ram #(
            .WIDTH (cmrl_pkg::ROW_W),
            .DEPTH (cmrl_pkg::LINES)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr[t]),
            .wr_data (wr_row[t]),
            .rd_en   (cmd.load),
            .rd_addr (rd_addr[t]),
            .rd_data (rd_row[t])
        );
    end

    assign wr_en = cmd.clear || (cmd.wr && under_reg);

    // Pick-hash digit: reciprocal estimate, then one correction.
    assign pick       = step_reg[1:0];
    assign tsel       = step_reg[cmrl_pkg::STEP_W-1];
    assign div        = cmrl_pkg::divisor(pick);
    assign prod       = cmrl_pkg::PROD_W'(hash_reg) * cmrl_pkg::PROD_W'(cmrl_pkg::recip(pick));
    assign q_est_next = cmrl_pkg::HASH_W'(prod >> cmrl_pkg::RECIP_SHIFT);
    assign qd         = cmrl_pkg::HASH_W'(q_est_reg * cmrl_pkg::HASH_W'(div));
    assign r_est      = hash_reg - qd;
    assign fix        = (r_est >= cmrl_pkg::HASH_W'(div));
    assign r_fix      = fix ? (r_est - cmrl_pkg::HASH_W'(div)) : r_est;
    assign q_next     = q_est_reg + cmrl_pkg::HASH_W'(fix);
    assign pos_hit    = cmrl_pkg::nth_zero(mask_reg[tsel], cmrl_pkg::pos_t'(r_fix));

    assign limit = '0 - price_reg;

    always_comb
    begin
        under_next = 1'b0;
        for (int s = 0; s < cmrl_pkg::SLOTS_PAD; s++)
        begin
            slot_val[s] = '1;
        end
        for (int t = 0; t < cmrl_pkg::TABLES; t++)
        begin
            for (int k = 0; k < cmrl_pkg::PER_LINE; k++)
            begin
                if (mask_reg[t][k])
                begin
                    slot_val[t * cmrl_pkg::PER_LINE + k] =
                        rd_row[t][k * cmrl_pkg::CNT_W +: cmrl_pkg::CNT_W];
                    if (rd_row[t][k * cmrl_pkg::CNT_W +: cmrl_pkg::CNT_W] < limit)
                    begin
                        under_next = 1'b1;
                    end
                end
            end
        end
        for (int g = 0; g < cmrl_pkg::MIN_GROUPS; g++)
        begin
            min8_next[g] = cmrl_pkg::min_of(
                cmrl_pkg::min_of(slot_val[4 * g], slot_val[4 * g + 1]),
                cmrl_pkg::min_of(slot_val[4 * g + 2], slot_val[4 * g + 3]));
        end
        for (int p = 0; p < cmrl_pkg::MIN_PAIRS; p++)
        begin
            min2_next[p] = cmrl_pkg::min_of(
                cmrl_pkg::min_of(min8_reg[4 * p], min8_reg[4 * p + 1]),
                cmrl_pkg::min_of(min8_reg[4 * p + 2], min8_reg[4 * p + 3]));
        end
    end

    assign add_full = {1'b0, min_reg} + {1'b0, price_reg};

    // Raise chosen counters below the new sum; zero rows during the clearing pass.
    always_comb
    begin
        for (int t = 0; t < cmrl_pkg::TABLES; t++)
        begin
            for (int k = 0; k < cmrl_pkg::PER_LINE; k++)
            begin
                cnt_v = rd_row[t][k * cmrl_pkg::CNT_W +: cmrl_pkg::CNT_W];
                if (cmd.clear)
                begin
                    wr_row[t][k * cmrl_pkg::CNT_W +: cmrl_pkg::CNT_W] = '0;
                end
                else if (mask_reg[t][k] && (cnt_v < sum_reg))
                begin
                    wr_row[t][k * cmrl_pkg::CNT_W +: cmrl_pkg::CNT_W] = sum_reg;
                end
                else
                begin
                    wr_row[t][k * cmrl_pkg::CNT_W +: cmrl_pkg::CNT_W] = cnt_v;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            clear_idx_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg <= '0;
            end
            else if (cmd.digit)
            begin
                step_reg <= step_reg + cmrl_pkg::step_t'(1);
            end
            if (cmd.clear)
            begin
                clear_idx_reg <= clear_idx_reg + cmrl_pkg::line_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            line_reg[0] <= rd_addr[0];
            line_reg[1] <= rd_addr[1];
            hash_reg    <= pick_hash;
            price_reg   <= price;
            mask_reg[0] <= '0;
            mask_reg[1] <= '0;
        end
        if (cmd.mul)
        begin
            q_est_reg <= q_est_next;
        end
        if (cmd.digit)
        begin
            hash_reg       <= q_next;
            mask_reg[tsel] <= mask_reg[tsel] | pos_hit;
        end
        if (cmd.scan)
        begin
            under_reg <= under_next;
            min8_reg  <= min8_next;
        end
        if (cmd.reduce1)
        begin
            min2_reg <= min2_next;
        end
        if (cmd.reduce2)
        begin
            min_reg <= cmrl_pkg::min_of(min2_reg[0], min2_reg[1]);
        end
        if (cmd.add)
        begin
            sum_reg <= add_full[cmrl_pkg::CNT_W] ? '1 : add_full[cmrl_pkg::CNT_W-1:0];
        end
        if (cmd.result)
        begin
            limited_reg <= !under_reg;
        end
    end

    assign status.digits_done = (step_reg == cmrl_pkg::step_t'(cmrl_pkg::STEPS - 1));
    assign status.clear_done  = (clear_idx_reg == cmrl_pkg::line_t'(cmrl_pkg::LINES - 1));
    assign limited            = limited_reg;

endmodule

// ----- rtl/core/cmrl_ctrl.sv -----
// Controller: sequences clearing, digit steps, limit check, update and result handoff.
// Depends on cmrl_pkg; drives cmrl_datapath through cmd_t and reads status_t.
module cmrl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output cmrl_pkg::cmd_t     cmd,
    input  cmrl_pkg::status_t  status
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_DIGIT,
        S_SCAN,
        S_RED1,
        S_RED2,
        S_ADD,
        S_WRITE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIGIT;
            end
            S_DIGIT:
            begin
                cmd.digit  = 1'b1;
                state_next = status.digits_done ? S_SCAN : S_MUL;
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_RED1;
            end
            S_RED1:
            begin
                cmd.reduce1 = 1'b1;
                state_next  = S_RED2;
            end
            S_RED2:
            begin
                cmd.reduce2 = 1'b1;
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/count_min_rate_limiter_unit.sv -----
// Count-min rate limiter with conservative update over two tables of 1024 lines, 15 x 32-bit
// counters per line. Requests are taken one at a time, with in_ready high only when idle: the pick
// hash is split into eight digits by constant divisors, each digit taking a reciprocal multiply
// step, then a correction and free-slot search step, followed by the limit check, minimum tree
// and write-back. After reset the counter RAMs are zeroed one line per cycle, both tables
// together, over all 1024 lines with in_ready low. The result sits in an output register,
// so a new request enters while the previous result waits for out_ready.
// Depends on cmrl_pkg, cmrl_ctrl, cmrl_datapath and cmrl_ram.
module count_min_rate_limiter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cmrl_pkg::FIELD_LINE_W-1:0]  line_first,
    input  logic [cmrl_pkg::FIELD_LINE_W-1:0]  line_second,
    input  logic [cmrl_pkg::HASH_W-1:0]        pick_hash,
    input  logic [cmrl_pkg::PRICE_W-1:0]       price,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               limited
);

    cmrl_pkg::cmd_t    cmd;
    cmrl_pkg::status_t status;

    cmrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    cmrl_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .line_first  (line_first),
        .line_second (line_second),
        .pick_hash   (pick_hash),
        .price       (price),
        .limited     (limited)
    );

endmodule
